[design/ppl_pkg.sv]
package ppl_pkg;

  // Palette geometry.
  localparam int PAL_ENTRIES = 256;
  localparam int PAL_AW      = $clog2(PAL_ENTRIES);
  localparam int PAL_W       = 24;

  // Input item kinds, carried on tuser.
  typedef enum logic [1:0] {
    KIND_PALETTE = 2'd0,
    KIND_PIXEL   = 2'd1,
    KIND_FRAME   = 2'd2,
    KIND_NONE    = 2'd3
  } kind_t;

  // Configuration register indexes.
  localparam logic [2:0] REG_X_START = 3'd0;
  localparam logic [2:0] REG_X_END   = 3'd1;
  localparam logic [2:0] REG_Y_START = 3'd2;
  localparam logic [2:0] REG_Y_END   = 3'd3;
  localparam logic [2:0] REG_ROTATE  = 3'd4;

  // LCD controller commands.
  localparam logic [7:0] CMD_COLUMN   = 8'h2A;
  localparam logic [7:0] CMD_ROW      = 8'h2B;
  localparam logic [7:0] CMD_MEMWRITE = 8'h2C;

  // Byte counter value at the last byte of each emitting item.
  localparam int         CNT_W       = 4;
  localparam logic [3:0] PIXEL_LAST  = 4'd1;
  localparam logic [3:0] FRAME_LAST  = 4'd11;

  // Conversion rounding constants.
  localparam logic [7:0]  MUL_RB = 8'd249;
  localparam logic [7:0]  MUL_G  = 8'd253;
  localparam logic [15:0] RND_RB = 16'd1024;
  localparam logic [15:0] RND_G  = 16'd512;

  typedef struct packed {
    logic [15:0] x_start;
    logic [15:0] x_end;
    logic [15:0] y_start;
    logic [15:0] y_end;
    logic        rotate;
  } cfg_t;

  // One converted item handed from the pipeline to the byte serializer.
  typedef struct packed {
    logic        valid;
    kind_t       kind;
    logic [15:0] word;
  } item_t;

endpackage

[design/ppl_ram.sv]
module ppl_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic                 re,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[design/ppl_conv.sv]
module ppl_conv (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  input  logic [31:0]     s_tdata,
  input  logic [1:0]      s_tuser,
  input  logic            ser_ready,
  output ppl_pkg::item_t  item
);
  import ppl_pkg::*;

  logic              en;
  logic [7:0]        idx;
  logic              idx_ok;
  logic              emits;
  logic              pal_we;
  logic [PAL_W-1:0]  q;

  // Stage 1: palette read issued.
  logic              v1;
  kind_t             k1;
  logic              ok1;
  // Stage 2: products.
  logic              v2;
  kind_t             k2;
  logic [15:0]       pr, pg, pb;
  // Stage 3: packed RGB565 word.
  logic              v3;
  kind_t             k3;
  logic [15:0]       w3;

  logic [PAL_W-1:0]  e;
  logic [15:0]       sr, sg, sb;

  assign en       = !v3 || ser_ready;
  assign s_tready = en;
  assign idx      = s_tdata[7:0];
  assign idx_ok   = {1'b0, idx} < 9'(PAL_ENTRIES);
  assign emits    = (kind_t'(s_tuser) == KIND_PIXEL) || (kind_t'(s_tuser) == KIND_FRAME);
  assign pal_we   = s_tvalid && en && (kind_t'(s_tuser) == KIND_PALETTE) && idx_ok;

  ppl_ram #(.W(PAL_W), .D(PAL_ENTRIES)) u_pal (
    .clk   (clk),
    .we    (pal_we),
    .waddr (idx[PAL_AW-1:0]),
    .wdata ({s_tdata[15:8], s_tdata[23:16], s_tdata[31:24]}),
    .re    (en),
    .raddr (idx[PAL_AW-1:0]),
    .rdata (q)
  );

  // An index past the palette converts as black.
  assign e  = ok1 ? q : '0;
  assign sr = pr + RND_RB;
  assign sg = pg + RND_G;
  assign sb = pb + RND_RB;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= s_tvalid && emits;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      k1  <= kind_t'(s_tuser);
      ok1 <= idx_ok;
      k2  <= k1;
      pr  <= 16'(e[23:16]) * 16'(MUL_RB);
      pg  <= 16'(e[15:8]) * 16'(MUL_G);
      pb  <= 16'(e[7:0]) * 16'(MUL_RB);
      k3  <= k2;
      w3  <= {sr[15:11], sg[15:10], sb[15:11]};
    end
  end

  assign item.valid = v3;
  assign item.kind  = k3;
  assign item.word  = w3;

endmodule

[design/ppl_ser.sv]
module ppl_ser (
  input  logic            clk,
  input  logic            rst,
  input  ppl_pkg::item_t  item,
  output logic            ser_ready,
  input  ppl_pkg::cfg_t   cfg,
  output logic            m_tvalid,
  input  logic            m_tready,
  output logic [7:0]      m_tdata,
  output logic [0:0]      m_tuser,
  output logic            m_tlast
);
  import ppl_pkg::*;

  logic               busy;
  kind_t              kind;
  logic [15:0]        word;
  logic [CNT_W-1:0]   cnt;
  logic               out_adv;
  logic               last_byte;
  logic [7:0]         sel;
  logic               sel_data;

  assign out_adv   = !m_tvalid || m_tready;
  assign last_byte = (kind == KIND_PIXEL) ? (cnt == PIXEL_LAST) : (cnt == FRAME_LAST);
  assign ser_ready = !busy || (out_adv && last_byte);

  always_comb begin
    sel      = CMD_MEMWRITE;
    sel_data = 1'b1;
    if (kind == KIND_PIXEL) begin
      sel = (cnt == '0) ? word[15:8] : word[7:0];
    end else begin
      case (cnt)
        4'd0: begin
          sel      = CMD_COLUMN;
          sel_data = 1'b0;
        end
        4'd1: sel = cfg.x_start[15:8];
        4'd2: sel = cfg.x_start[7:0];
        4'd3: sel = cfg.x_end[15:8];
        4'd4: sel = cfg.x_end[7:0];
        4'd5: begin
          sel      = CMD_ROW;
          sel_data = 1'b0;
        end
        4'd6: sel = cfg.y_start[15:8];
        4'd7: sel = cfg.y_start[7:0];
        4'd8: sel = cfg.y_end[15:8];
        4'd9: sel = cfg.y_end[7:0];
        default: begin
          sel      = CMD_MEMWRITE;
          sel_data = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (out_adv) begin
        m_tvalid <= busy;
      end
      if (ser_ready) begin
        busy <= item.valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ser_ready) begin
      kind <= item.kind;
      word <= item.word;
      cnt  <= '0;
    end else if (busy && out_adv) begin
      cnt <= cnt + 1'b1;
    end
    if (out_adv && busy) begin
      m_tdata    <= cfg.rotate ? {sel[1:0], sel[7:2]} : sel;
      m_tuser[0] <= sel_data;
      m_tlast    <= last_byte;
    end
  end

endmodule

[design/paletted_pixel_to_rgb565_lcd_bus.sv]
// Paletted pixel to RGB565 byte streamer for an 8-bit parallel LCD bus. Each input
// word carries a kind on s_tuser: a palette write stores an RGB888 entry and sends
// nothing, a pixel looks up its entry, rounds it to RGB565 and sends the high byte
// then the low byte as data, and a frame start sends the window sequence (column
// command with x start and end, row command with y start and end, then the memory
// write command twice). Kind 3 is dropped. Every output byte is rotated right by
// two bits when bus_rotate is set. m_tuser is the register select line (1 data,
// 0 command) and m_tlast marks the final byte of each input word. The pipeline is
// five register stages deep (palette read, multiply, round and pack, serializer
// hold, output register), and a new input word can enter every cycle unless the
// serializer stalls the pipeline. The sustained rate is set by the single byte
// lane at the output: a pixel sends two bytes, a frame start twelve, and palette
// writes send none. A palette write is seen by a pixel in the very next word. Palette
// entries hold no value until written; there is no clearing pass after reset.
// Window and rotation registers should be written only while no word is in flight.
module paletted_pixel_to_rgb565_lcd_bus (
  input  logic        clk,
  input  logic        rst,
  // Configuration write port.
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  // Input stream.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // color_index, red_level, green_level, blue_level
  input  logic [1:0]  s_tuser,   // func
  // Output stream.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // bus_byte
  output logic [0:0]  m_tuser,   // is_data
  output logic        m_tlast
);
  import ppl_pkg::*;

  cfg_t  cfg;
  item_t item;
  logic  ser_ready;

  // Window and wiring registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.x_start <= 16'd0;
      cfg.x_end   <= 16'd319;
      cfg.y_start <= 16'd0;
      cfg.y_end   <= 16'd199;
      cfg.rotate  <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_X_START: cfg.x_start <= cfg_data;
        REG_X_END:   cfg.x_end   <= cfg_data;
        REG_Y_START: cfg.y_start <= cfg_data;
        REG_Y_END:   cfg.y_end   <= cfg_data;
        REG_ROTATE:  cfg.rotate  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Palette lookup and RGB565 conversion pipeline.
  ppl_conv u_conv (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .ser_ready (ser_ready),
    .item      (item)
  );

  // Byte serializer with the output register.
  ppl_ser u_ser (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .ser_ready (ser_ready),
    .cfg       (cfg),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

endmodule

[sim/lcd_stream_checker.sv]
`timescale 1ns / 100ps

// Watches the configuration port and both stream channels of the LCD byte
// streamer. It keeps its own copy of the window, rotation and palette,
// predicts the bus bytes of every accepted input word and compares each
// accepted output byte against the oldest prediction.
module lcd_stream_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [31:0] s_tdata,
  input  logic [1:0]  s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [7:0]  m_tdata,
  input  logic [0:0]  m_tuser,
  input  logic        m_tlast,
  output int          fail_count,
  output int          pending
);
  import ppl_pkg::*;

  localparam logic [15:0] RESET_X_END = 16'd319;
  localparam logic [15:0] RESET_Y_END = 16'd199;

  typedef struct packed {
    logic [7:0] bus_byte;
    logic       is_data;
    logic       last;
  } lcd_byte_t;

  lcd_byte_t   due_bytes[$];
  logic [23:0] palette_shadow [PAL_ENTRIES];
  cfg_t        window;
  int          mismatches = 0;
  int          byte_count = 0;

  function automatic logic [7:0] on_wire(logic [7:0] value);
    return window.rotate ? {value[1:0], value[7:2]} : value;
  endfunction

  function automatic void queue_byte(logic [7:0] value, logic is_data, logic last);
    lcd_byte_t entry;
    entry.bus_byte = on_wire(value);
    entry.is_data  = is_data;
    entry.last     = last;
    due_bytes.push_back(entry);
  endfunction

  // RGB888 to RGB565 with the rounding multipliers of the LCD driver.
  function automatic logic [15:0] rgb565_of(logic [23:0] entry);
    int r5;
    int g6;
    int b5;
    r5 = (int'(entry[23:16]) * int'(MUL_RB) + int'(RND_RB)) >> 11;
    g6 = (int'(entry[15:8]) * int'(MUL_G) + int'(RND_G)) >> 10;
    b5 = (int'(entry[7:0]) * int'(MUL_RB) + int'(RND_RB)) >> 11;
    return {r5[4:0], g6[5:0], b5[4:0]};
  endfunction

  task automatic report_mismatch(string message);
    $display("%0t ns: output byte %0d: %s", $time, byte_count, message);
    mismatches++;
  endtask

  always @(posedge clk) begin : watch
    lcd_byte_t   expected;
    logic [15:0] rgb;
    if (rst) begin
      window.x_start = '0;
      window.x_end   = RESET_X_END;
      window.y_start = '0;
      window.y_end   = RESET_Y_END;
      window.rotate  = 1'b1;
      due_bytes.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_X_START: window.x_start = cfg_data;
          REG_X_END:   window.x_end   = cfg_data;
          REG_Y_START: window.y_start = cfg_data;
          REG_Y_END:   window.y_end   = cfg_data;
          REG_ROTATE:  window.rotate  = cfg_data[0];
          default: ;
        endcase
      end

      if (s_tvalid && s_tready) begin
        case (kind_t'(s_tuser))
          KIND_PALETTE: begin
            palette_shadow[s_tdata[7:0]] = {s_tdata[15:8], s_tdata[23:16], s_tdata[31:24]};
          end
          KIND_PIXEL: begin
            rgb = rgb565_of(palette_shadow[s_tdata[7:0]]);
            queue_byte(rgb[15:8], 1'b1, 1'b0);
            queue_byte(rgb[7:0], 1'b1, 1'b1);
          end
          KIND_FRAME: begin
            queue_byte(CMD_COLUMN, 1'b0, 1'b0);
            queue_byte(window.x_start[15:8], 1'b1, 1'b0);
            queue_byte(window.x_start[7:0], 1'b1, 1'b0);
            queue_byte(window.x_end[15:8], 1'b1, 1'b0);
            queue_byte(window.x_end[7:0], 1'b1, 1'b0);
            queue_byte(CMD_ROW, 1'b0, 1'b0);
            queue_byte(window.y_start[15:8], 1'b1, 1'b0);
            queue_byte(window.y_start[7:0], 1'b1, 1'b0);
            queue_byte(window.y_end[15:8], 1'b1, 1'b0);
            queue_byte(window.y_end[7:0], 1'b1, 1'b0);
            queue_byte(CMD_MEMWRITE, 1'b0, 1'b0);
            queue_byte(CMD_MEMWRITE, 1'b0, 1'b1);
          end
          default: ;
        endcase
      end

      if (m_tvalid && m_tready) begin
        if (due_bytes.size() == 0) begin
          report_mismatch($sformatf("unexpected word %02h", m_tdata));
        end else begin
          expected = due_bytes.pop_front();
          if (m_tdata !== expected.bus_byte)
            report_mismatch($sformatf("bus_byte expected %02h got %02h",
                                      expected.bus_byte, m_tdata));
          if (m_tuser[0] !== expected.is_data)
            report_mismatch($sformatf("is_data expected %0b got %0b",
                                      expected.is_data, m_tuser[0]));
          if (m_tlast !== expected.last)
            report_mismatch($sformatf("last expected %0b got %0b",
                                      expected.last, m_tlast));
        end
        byte_count++;
      end
    end
    pending    <= due_bytes.size();
    fail_count <= mismatches;
  end

endmodule

[sim/testbench.sv]
`timescale 1ns / 100ps

// Top of the LCD byte streamer bench. This module only makes stimulus and
// gives the verdict; the checker beside the block does all prediction and
// comparison and hands back its failure count and the number of bytes it
// still expects.
module testbench;
  import ppl_pkg::*;

  // Indexes past the register list; writes to them must change nothing.
  localparam logic [2:0] REG_UNUSED_LO = 3'd5;
  localparam logic [2:0] REG_UNUSED_HI = 3'd7;

  // Five register stages plus margin; palette writes leave no output trace,
  // so this many quiet cycles are allowed before touching the registers.
  localparam int SETTLE_CYCLES  = 10;
  localparam int HOLD_CYCLES    = 160;
  localparam int WATCHDOG_LIMIT = 1500;
  localparam int RANDOM_PHASES  = 5;
  localparam int RUN_ITEMS      = 8;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;   // color_index, red_level, green_level, blue_level
  logic [1:0]  s_tuser = '0;   // func
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;        // bus_byte
  logic [0:0]  m_tuser;        // is_data
  logic        m_tlast;

  int fail_count;
  int pending;
  int quiet_cycles = 0;

  // Calm turns off all random idling for the last stretch of the run.
  // Hold asks the receiver for one long stall, which it serves only once.
  logic calm = 1'b0;
  logic hold_req = 1'b0;

  // Palette entries that have been written. Pixels only look these up,
  // since an entry that was never written has no defined color.
  logic [7:0] known_colors[$];
  bit         color_seen [PAL_ENTRIES];

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  paletted_pixel_to_rgb565_lcd_bus dut (.*);

  lcd_stream_checker lcd_check (.*);

  // Receiver side: mostly ready, with random stall bursts, and one long
  // hold on request so that the pipeline backs up into the input.
  initial begin : receiver
    bit hold_done;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        m_tready <= 1'b1;
        hold_done = 1'b1;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b1;
        repeat ($urandom_range(0, 20)) @(posedge clk);
      end
    end
  end

  // The watchdog fires when neither channel has moved a word for too long.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles, %0d bytes still expected",
               WATCHDOG_LIMIT, pending);
      $display("== FAIL ==");
      $finish;
    end
  end

  // Offers one word and returns at the edge where it is taken. A random
  // gap may come first; valid then stays high until the handshake.
  task automatic send_word(kind_t kind, logic [7:0] idx, logic [7:0] red,
                           logic [7:0] green, logic [7:0] blue);
    if (!calm && $urandom_range(0, 2) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {blue, green, red, idx};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic write_color(logic [7:0] idx, logic [7:0] red, logic [7:0] green,
                             logic [7:0] blue);
    send_word(KIND_PALETTE, idx, red, green, blue);
    if (!color_seen[idx]) begin
      color_seen[idx] = 1'b1;
      known_colors.push_back(idx);
    end
  endtask

  // Stops offering and waits until every predicted byte has come out, then
  // lets the pipeline empty of any trailing palette writes.
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic put_reg(logic [2:0] index, logic [15:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(posedge clk);
  endtask

  // Rewrites every register while the block is idle, plus the unused
  // indexes, which must be ignored.
  task automatic load_settings(logic [15:0] x_first, logic [15:0] x_last,
                               logic [15:0] y_first, logic [15:0] y_last,
                               logic rotate);
    int spare;
    settle();
    put_reg(REG_X_START, x_first);
    put_reg(REG_X_END, x_last);
    put_reg(REG_Y_START, y_first);
    put_reg(REG_Y_END, y_last);
    put_reg(REG_ROTATE, {15'($urandom_range(0, 16'h7FFF)), rotate});
    for (spare = REG_UNUSED_LO; spare <= REG_UNUSED_HI; spare++)
      put_reg(spare[2:0], 16'($urandom));
    cfg_we <= 1'b0;
  endtask

  // A run of random words: palette writes, pixels over known entries, frame
  // starts and the occasional unused kind, which does not count.
  task automatic send_random_run(int count);
    int         done_items;
    int         pick;
    logic [7:0] idx;
    done_items = 0;
    while (done_items < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 30 || known_colors.size() == 0) begin
        write_color(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        done_items++;
      end else if (pick < 75) begin
        idx = known_colors[$urandom_range(0, known_colors.size() - 1)];
        send_word(KIND_PIXEL, idx, 8'($urandom), 8'($urandom), 8'($urandom));
        done_items++;
      end else if (pick < 88) begin
        send_word(KIND_FRAME, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        done_items++;
      end else begin
        send_word(KIND_NONE, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      end
    end
  endtask

  initial begin : stimulus
    int phase;
    int burst;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Window sequence at the reset settings, with rotation on.
    send_word(KIND_FRAME, 8'h00, 8'h00, 8'h00, 8'h00);
    // The unused kind with every bit set must leave no trace.
    send_word(KIND_NONE, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    // Black and white at the two ends of the palette.
    write_color(8'h00, 8'h00, 8'h00, 8'h00);
    send_word(KIND_PIXEL, 8'h00, 8'h00, 8'h00, 8'h00);
    write_color(8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_word(KIND_PIXEL, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    // Alternating bit patterns.
    write_color(8'h55, 8'hAA, 8'h55, 8'h0F);
    send_word(KIND_PIXEL, 8'h55, 8'h00, 8'h00, 8'h00);
    // Levels on either side of a rounding step in each channel.
    write_color(8'hAA, 8'h05, 8'h02, 8'h04);
    send_word(KIND_PIXEL, 8'hAA, 8'h00, 8'h00, 8'h00);
    // A pixel right behind the write that changed its entry.
    write_color(8'h55, 8'h04, 8'h03, 8'h05);
    send_word(KIND_PIXEL, 8'h55, 8'h00, 8'h00, 8'h00);
    send_word(KIND_NONE, 8'h00, 8'h00, 8'h00, 8'h00);
    send_word(KIND_FRAME, 8'hFF, 8'hFF, 8'hFF, 8'hFF);

    // Opposite window extremes with rotation off.
    load_settings(16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000, 1'b0);
    send_word(KIND_FRAME, 8'h00, 8'h00, 8'h00, 8'h00);
    send_word(KIND_PIXEL, 8'hFF, 8'h00, 8'h00, 8'h00);
    send_word(KIND_PIXEL, 8'hAA, 8'h00, 8'h00, 8'h00);
    send_word(KIND_NONE, 8'h5A, 8'hA5, 8'h5A, 8'hA5);

    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      if (phase == 0)
        load_settings(16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF, 1'b1);
      else
        load_settings(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                      phase[0]);
      if (phase == RANDOM_PHASES - 1)
        calm <= 1'b1;

      // Long receiver hold while frames and pixels keep coming, so the
      // block fills up and has to stall its input.
      if (phase == 2) begin
        hold_req <= 1'b1;
        for (burst = 0; burst < 8; burst++) begin
          if (burst[0])
            send_word(KIND_PIXEL, known_colors[$urandom_range(0, known_colors.size() - 1)],
                      8'($urandom), 8'($urandom), 8'($urandom));
          else
            send_word(KIND_FRAME, 8'($urandom), 8'($urandom), 8'($urandom),
                      8'($urandom));
        end
      end

      send_random_run(RUN_ITEMS);
      // Once, the sender waits until every expected byte has come out.
      if (phase == 3)
        settle();
      send_random_run(RUN_ITEMS);
    end

    settle();
    if (fail_count == 0 && pending == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

[filelist.f]
design/ppl_pkg.sv
design/ppl_ram.sv
design/ppl_conv.sv
design/ppl_ser.sv
design/paletted_pixel_to_rgb565_lcd_bus.sv
sim/lcd_stream_checker.sv
sim/testbench.sv
